@@ rtl/core/pcac_pkg.sv @@
`default_nettype none

package pcac_pkg;

  // Configuration register map: four 64-bit words of PN code chips.
  typedef enum logic [1:0] {
    CFG_CODE_0 = 2'd0,
    CFG_CODE_1 = 2'd1,
    CFG_CODE_2 = 2'd2,
    CFG_CODE_3 = 2'd3
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CODE_W     = 64;
  localparam int CODE_WORDS = 4;

  // Result field widths.
  localparam int OFF_W     = 12;
  localparam int SCORE_W   = 9;
  localparam int SCORE_MAX = 255;

endpackage

`default_nettype wire

@@ rtl/core/pn_code_acquisition_correlator.sv @@
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | in_chip_bit, in_last_chip
// out     | output    | out_valid / out_stall | out_found, out_best_offset,
//         |           |                       | out_best_score, out_overflow
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The block takes one chip every cycle while in_stall is low; the transposed
// chain of correlator cells advances once per accepted chip, so a window is
// scored in the cycle its newest chip arrives.
// The result of a search sits in the output register from the cycle after
// its last chip is accepted until it is taken.
// in_stall rises only while a result is held and out_stall is high.
// rst_n is synchronous and active low; it clears the code registers and the
// search state, and the block is ready in the first cycle after reset.
//
// Structure: chip k of the code is compared against the chip that arrived
// CODE_LEN-1-k chips before the newest one. Instead of shifting a chip
// window and counting mismatches across all of it, each cell holds a partial
// mismatch count that travels toward the head of the chain one step per
// chip, picking up that cell's mismatch bit for the current chip on the way.
// The head tap is summed combinationally, which yields the mismatch count of
// the full window that ends at the current chip. Partial counts older than
// CODE_LEN chips have fallen out of the chain, so no clearing is needed
// between searches: a window is only scored once CODE_LEN chips of the
// current search have been taken.
module pn_code_acquisition_correlator #(
  parameter int CODE_LEN = 255,
  parameter int MAX_LEN  = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Chip input.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_chip_bit,
  input  wire logic                                in_last_chip,
  // Search result.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_found,
  output logic        [pcac_pkg::OFF_W-1:0]        out_best_offset,
  output logic signed [pcac_pkg::SCORE_W-1:0]      out_best_score,
  output logic                                     out_overflow,
  // Code register writes.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic   [pcac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic   [pcac_pkg::CODE_W-1:0]       cfg_data
);

  // Mismatch count width, chip counter width and internal score width.
  localparam int MW    = $clog2(CODE_LEN + 1);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SW    = (MW + 2 > pcac_pkg::SCORE_W + 1) ? MW + 2
                                                          : pcac_pkg::SCORE_W + 1;
  localparam int CODE_BITS = pcac_pkg::CODE_WORDS * pcac_pkg::CODE_W;

  // ---------------------------------------------------------------------
  // Code registers.
  // ---------------------------------------------------------------------
  logic [CODE_BITS-1:0] code_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else if (cfg_valid) begin
      case (pcac_pkg::cfg_idx_t'(cfg_index))
        pcac_pkg::CFG_CODE_0: code_r[0*pcac_pkg::CODE_W +: pcac_pkg::CODE_W] <= cfg_data;
        pcac_pkg::CFG_CODE_1: code_r[1*pcac_pkg::CODE_W +: pcac_pkg::CODE_W] <= cfg_data;
        pcac_pkg::CFG_CODE_2: code_r[2*pcac_pkg::CODE_W +: pcac_pkg::CODE_W] <= cfg_data;
        pcac_pkg::CFG_CODE_3: code_r[3*pcac_pkg::CODE_W +: pcac_pkg::CODE_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and chip counting.
  // ---------------------------------------------------------------------
  logic             in_acc;
  logic             cnt_sat;
  logic             step;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_inc;

  // A new chip can always be taken unless a result is held and blocked.
  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  // Chips beyond MAX_LEN are not scored; they flag overflow.
  assign cnt_sat   = (count_r == CNT_W'(MAX_LEN));
  assign step      = in_acc && !cnt_sat;
  assign count_inc = count_r + CNT_W'(1);

  // ---------------------------------------------------------------------
  // Correlator cell chain. Cell i pairs the current chip with code chip
  // CODE_LEN-1-i; link[i] is cell i's partial count.
  // ---------------------------------------------------------------------
  logic [MW-1:0] link [1:CODE_LEN];

  assign link[CODE_LEN] = '0;

  for (genvar i = 1; i < CODE_LEN; i++) begin : g_cell
    pcac_cell #(
      .W (MW)
    ) u_cell (
      .clk     (clk),
      .en      (step),
      .mis     (in_chip_bit ^ code_r[CODE_LEN-1-i]),
      .sum_in  (link[i+1]),
      .sum_out (link[i])
    );
  end

  // Head tap: the newest chip against the last code chip.
  logic [MW-1:0]        mism;
  logic signed [SW-1:0] score;

  assign mism  = link[1] + MW'(in_chip_bit ^ code_r[CODE_LEN-1]);
  assign score = $signed(SW'(CODE_LEN)) - $signed({{(SW-MW-1){1'b0}}, mism, 1'b0});

  // ---------------------------------------------------------------------
  // Best-window tracking.
  // ---------------------------------------------------------------------
  logic                        found_r,  found_nxt;
  logic signed [SW-1:0]        best_r,   best_nxt;
  logic [pcac_pkg::OFF_W-1:0]  off_r,    off_nxt;
  logic                        ovf_r,    ovf_nxt;
  logic [CNT_W-1:0]            count_nxt;
  logic                        full;
  logic                        take;

  assign full = (count_inc >= CNT_W'(CODE_LEN));
  // The first scored window always wins; later ones only on a strictly
  // better score, so a tie keeps the earlier offset.
  assign take = step && full && (!found_r || (score > best_r));

  always_comb begin
    count_nxt = step ? count_inc : count_r;
    found_nxt = found_r || take;
    best_nxt  = take ? score : best_r;
    off_nxt   = take ? pcac_pkg::OFF_W'(count_inc - CNT_W'(CODE_LEN)) : off_r;
    ovf_nxt   = ovf_r || (in_acc && cnt_sat);
  end

  // Result formatting from the post-update search state.
  logic signed [pcac_pkg::SCORE_W-1:0] res_score;

  always_comb begin
    if (found_nxt) begin
      if (best_nxt > $signed(SW'(pcac_pkg::SCORE_MAX))) begin
        res_score = pcac_pkg::SCORE_W'(pcac_pkg::SCORE_MAX);
      end else if (best_nxt < -$signed(SW'(pcac_pkg::SCORE_MAX))) begin
        res_score = -pcac_pkg::SCORE_W'(pcac_pkg::SCORE_MAX);
      end else begin
        res_score = pcac_pkg::SCORE_W'(best_nxt);
      end
    end else if (count_nxt > CNT_W'(pcac_pkg::SCORE_MAX)) begin
      res_score = -pcac_pkg::SCORE_W'(pcac_pkg::SCORE_MAX);
    end else begin
      // Short stream: the score reports minus the chip count.
      res_score = pcac_pkg::SCORE_W'(0) - pcac_pkg::SCORE_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      found_r <= 1'b0;
      best_r  <= -$signed(SW'(pcac_pkg::SCORE_MAX));
      off_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (in_acc && in_last_chip) begin
      // End of search: clear for the next block of chips.
      count_r <= '0;
      found_r <= 1'b0;
      best_r  <= -$signed(SW'(pcac_pkg::SCORE_MAX));
      off_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      found_r <= found_nxt;
      best_r  <= best_nxt;
      off_r   <= off_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic                                out_valid_r;
  logic                                out_found_r;
  logic [pcac_pkg::OFF_W-1:0]          out_off_r;
  logic signed [pcac_pkg::SCORE_W-1:0] out_score_r;
  logic                                out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_last_chip) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_chip) begin
      out_found_r <= found_nxt;
      out_off_r   <= found_nxt ? off_nxt : '0;
      out_score_r <= res_score;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_best_offset = out_off_r;
  assign out_best_score  = out_score_r;
  assign out_overflow    = out_ovf_r;

endmodule

`default_nettype wire

@@ rtl/core/pcac_cell.sv @@
`default_nettype none

// One tap of the transposed correlator: adds this tap's mismatch bit to the
// partial count handed over by its upstream neighbor.
module pcac_cell #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic         mis,
  input  wire logic [W-1:0] sum_in,
  output logic      [W-1:0] sum_out
);

  logic [W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_in + W'(mis);
    end
  end

  assign sum_out = sum_r;

endmodule

`default_nettype wire

@@ rtl/core/pcac_chk.sv @@
`default_nettype none

// Port-level checks for the correlator.
module pcac_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                in_last_chip,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic                                out_found,
  input wire logic        [pcac_pkg::OFF_W-1:0]   out_best_offset,
  input wire logic signed [pcac_pkg::SCORE_W-1:0] out_best_score,
  input wire logic                                out_overflow
);

  // A blocked result holds its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_best_offset) && $stable(out_best_score) && $stable(out_overflow))
    else $error("result beat changed while stalled");

  // A last chip always yields a result beat in the next cycle.
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_chip |=> out_valid)
    else $error("last chip gave no result");

  // The input is held back only by a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Without a scored window the offset is zero and the score is not positive.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_offset == '0 && out_best_score <= 0)
    else $error("bad result for a short stream");

endmodule

bind pn_code_acquisition_correlator pcac_chk u_pcac_chk (.*);

`default_nettype wire
